// ----- rtl/sefp_pkg.sv -----
// ----------------------------------------------------------------------------
// sefp_pkg
// Shared constants, types and the CRC-8 byte update for the frame parser.
// ----------------------------------------------------------------------------
package sefp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int STAT_W      = 2;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_CRC = 2'd1;
  localparam logic [STAT_W-1:0] ST_FMT = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [LEN_W-1:0]  payload_limit;
  } cfg_t;

  typedef struct packed {
    logic take_len;
    logic take_cmd;
    logic take_data;
    logic take_crc;
    logic put_fmt;
    logic put_crc;
    logic put_empty;
    logic emit_start;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic start_match;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic end_ok;
    logic crc_ok;
    logic emit_last;
    logic out_hold;
  } dp_sts_t;

  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sefp_cfg.sv -----
// ----------------------------------------------------------------------------
// sefp_cfg
// APB register file: start byte, end byte and payload length limit.
// ----------------------------------------------------------------------------
module sefp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sefp_pkg::ADDR_W-1:0] paddr,
  input  logic [sefp_pkg::DATA_W-1:0] pwdata,
  output logic [sefp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sefp_pkg::cfg_t              cfg
);
  import sefp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= 8'd2;
      cfg.end_byte      <= 8'd3;
      cfg.payload_limit <= LIMIT_MAX;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START: cfg.start_byte    <= pwdata[BYTE_W-1:0];
        REG_END:   cfg.end_byte      <= pwdata[BYTE_W-1:0];
        REG_LIMIT: cfg.payload_limit <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START: prdata = DATA_W'(cfg.start_byte);
      REG_END:   prdata = DATA_W'(cfg.end_byte);
      REG_LIMIT: prdata = DATA_W'(cfg.payload_limit);
      default:   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sefp_ctrl.sv -----
// ----------------------------------------------------------------------------
// sefp_ctrl
// Frame state machine: sequences the datapath over hunt, header, payload,
// trailer and payload emission.
// ----------------------------------------------------------------------------
module sefp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sefp_pkg::dp_sts_t sts,
  output sefp_pkg::dp_cmd_t cmd
);
  import sefp_pkg::*;

  localparam logic [2:0] S_HUNT = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_CMD  = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_CRC  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       acc;

  assign in_stall = (state == S_EMIT) || sts.out_hold;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HUNT: begin
        if (acc && sts.start_match) state_next = S_LEN;
      end
      S_LEN: begin
        if (acc) begin
          if (sts.len_bad) begin
            cmd.put_fmt = 1'b1;
            state_next  = sts.start_match ? S_LEN : S_HUNT;
          end else begin
            cmd.take_len = 1'b1;
            state_next   = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (acc) begin
          cmd.take_cmd = 1'b1;
          state_next   = sts.len_zero ? S_CRC : S_DATA;
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.take_data = 1'b1;
          if (sts.data_done) state_next = S_CRC;
        end
      end
      S_CRC: begin
        if (acc) begin
          cmd.take_crc = 1'b1;
          state_next   = S_END;
        end
      end
      S_END: begin
        if (acc) begin
          state_next = S_HUNT;
          if (!sts.end_ok) begin
            cmd.put_fmt = 1'b1;
          end else if (!sts.crc_ok) begin
            cmd.put_crc = 1'b1;
          end else if (sts.len_zero) begin
            cmd.put_empty = 1'b1;
          end else begin
            cmd.emit_start = 1'b1;
            state_next     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_hold) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) state_next = S_HUNT;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/sefp_dp.sv -----
// ----------------------------------------------------------------------------
// sefp_dp
// Frame datapath: header registers, CRC-8 accumulator, payload buffer and
// the result output register.
// ----------------------------------------------------------------------------
module sefp_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  sefp_pkg::cfg_t              cfg,
  input  logic [sefp_pkg::BYTE_W-1:0] rx_byte,
  input  sefp_pkg::dp_cmd_t           cmd,
  output sefp_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sefp_pkg::STAT_W-1:0] status,
  output logic [sefp_pkg::BYTE_W-1:0] command,
  output logic [sefp_pkg::LEN_W-1:0]  payload_length,
  output logic [sefp_pkg::BYTE_W-1:0] payload_byte,
  output logic [sefp_pkg::IDX_W-1:0]  byte_index,
  output logic                        last
);
  import sefp_pkg::*;

  logic [LEN_W-1:0]  frame_length;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] command_reg;
  logic [BYTE_W-1:0] received_crc;
  logic [IDX_W-1:0]  emit_idx;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  emit_inc;
  logic              put_any;
  logic              load;

  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

  assign limit     = (cfg.payload_limit > LIMIT_MAX) ? LIMIT_MAX : cfg.payload_limit;
  assign count_inc = byte_count + 7'd1;
  assign emit_inc  = {1'b0, emit_idx} + 7'd1;
  assign put_any   = cmd.put_fmt || cmd.put_crc || cmd.put_empty;
  assign load      = put_any || cmd.emit_step;

  assign sts.start_match = (rx_byte == cfg.start_byte);
  assign sts.len_bad     = (rx_byte > {1'b0, limit});
  assign sts.len_zero    = (frame_length == '0);
  assign sts.data_done   = (count_inc >= frame_length);
  assign sts.end_ok      = (rx_byte == cfg.end_byte);
  assign sts.crc_ok      = (running_crc == received_crc);
  assign sts.emit_last   = (emit_inc == frame_length);
  assign sts.out_hold    = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      byte_count   <= '0;
      running_crc  <= CRC_INIT;
      command_reg  <= '0;
      received_crc <= '0;
      emit_idx     <= '0;
    end else begin
      if (cmd.take_len) begin
        frame_length <= rx_byte[LEN_W-1:0];
        running_crc  <= crc8_byte(CRC_INIT, rx_byte);
      end
      if (cmd.take_cmd) begin
        command_reg <= rx_byte;
        running_crc <= crc8_byte(running_crc, rx_byte);
        byte_count  <= '0;
      end
      if (cmd.take_data) begin
        running_crc <= crc8_byte(running_crc, rx_byte);
        byte_count  <= count_inc;
      end
      if (cmd.take_crc) received_crc <= rx_byte;
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_step) begin
        emit_idx <= emit_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_data) payload_mem[byte_count[IDX_W-1:0]] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      payload_byte <= payload_mem[emit_idx];
    end else if (put_any) begin
      payload_byte <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= put_any || sts.emit_last;
      if (cmd.emit_step) begin
        status         <= ST_OK;
        command        <= command_reg;
        payload_length <= frame_length;
        byte_index     <= emit_idx;
      end else begin
        status         <= cmd.put_fmt ? ST_FMT : (cmd.put_crc ? ST_CRC : ST_OK);
        command        <= cmd.put_empty ? command_reg : '0;
        payload_length <= '0;
        byte_index     <= '0;
      end
    end
  end

endmodule

// ----- rtl/stx_etx_frame_parser_crc8_unit.sv -----
// ----------------------------------------------------------------------------
// stx_etx_frame_parser_crc8_unit
// STX/ETX deframer with CRC-8 (poly 0x07) check and buffered payload output.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while a frame is parsed. A frame that
// checks out with N payload bytes is then sent as N result transfers, one per
// cycle from the payload buffer unless the sink stalls; in_stall stays high
// meanwhile. An error, or an empty frame, gives a single result transfer on
// the byte that causes it. in_stall is also high while a result
// waits in the output register and the sink stalls. No clearing pass after
// reset: the payload buffer is only read at entries of the current frame.
module stx_etx_frame_parser_crc8_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sefp_pkg::ADDR_W-1:0] paddr,
  input  logic [sefp_pkg::DATA_W-1:0] pwdata,
  output logic [sefp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sefp_pkg::BYTE_W-1:0] rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sefp_pkg::STAT_W-1:0] status,
  output logic [sefp_pkg::BYTE_W-1:0] command,
  output logic [sefp_pkg::LEN_W-1:0]  payload_length,
  output logic [sefp_pkg::BYTE_W-1:0] payload_byte,
  output logic [sefp_pkg::IDX_W-1:0]  byte_index,
  output logic                        last
);
  import sefp_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  sefp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sefp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sefp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .command        (command),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last)
  );

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last && (command == '0) && (payload_length == '0))
    else $error("error result is not a single cleared transfer");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (payload_length != '0) |-> ({1'b0, byte_index} < payload_length))
    else $error("byte_index outside payload");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (payload_length != '0) |->
      (last == (({1'b0, byte_index} + 7'd1) == payload_length)))
    else $error("last not on final payload byte");
`endif

endmodule
